FILE: hw/rtl/tpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared types, constants and width helpers of the trapezoid profile
// integrator.
// ----------------------------------------------------------------------------
package tpi_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int DEPTH_W = 17;
    localparam int HALF_W  = 31;
    localparam int RAMP_W  = 31;
    localparam int POINT_W = 32;
    localparam int VALUE_W = 35;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [DEPTH_W-1:0] DEPTH_RST = 17'd6554;
    localparam logic [HALF_W-1:0]  HALF_RST  = 31'd6554;
    localparam logic [RAMP_W-1:0]  RAMP_RST  = 31'd13107;

    // divisor is twice the ramp width; quotient never exceeds depth * ramp
    localparam int DEN_W = RAMP_W + 1;
    localparam int QUO_W = DEPTH_W + RAMP_W;
    localparam int NUM_W = DEN_W + QUO_W;

    localparam longint OUT_MAX = 64'sd17179869183;
    localparam longint OUT_MIN = -64'sd17179869184;

    typedef enum logic [0:0] {
        OP_EVAL  = 1'b0,
        OP_INTEG = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH = 2'd0,
        REG_HALF  = 2'd1,
        REG_RAMP  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [HALF_W-1:0]  half;
        logic [RAMP_W-1:0]  ramp;
    } t_cfg;

    typedef struct packed {
        t_op  op;
        logic zero;
        logic neg;
        logic flat;
        logic ramp;
        logic rzero;
    } t_flags;

    // signed width of the exact area, which carries FRAC_BITS fraction bits
    function automatic int area_width(input int frac);
        return ((frac + 33 > 50) ? frac + 33 : 50) + 2;
    endfunction

    // signed width of a profile value
    function automatic int eval_width(input int frac);
        return ((frac > DEPTH_W) ? frac : DEPTH_W) + 3;
    endfunction

endpackage

FILE: hw/rtl/tpi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_front
// Segment clipping, ramp squares, linear area and divider numerator over
// six pipeline stages.
// ----------------------------------------------------------------------------
module tpi_front #(
    parameter int FRAC_BITS = tpi_pkg::FRAC_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  tpi_pkg::t_op                             i_op,
    input  logic signed [tpi_pkg::POINT_W-1:0]       i_point_a,
    input  logic signed [tpi_pkg::POINT_W-1:0]       i_point_b,
    input  tpi_pkg::t_cfg                            i_cfg,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic [tpi_pkg::NUM_W-1:0]                o_num,
    output logic signed [tpi_pkg::area_width(FRAC_BITS)-1:0] o_lin,
    output tpi_pkg::t_flags                          o_flags
);

    localparam int AW = tpi_pkg::area_width(FRAC_BITS);
    localparam int NW = tpi_pkg::NUM_W;

    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    // stage 1: input request
    logic                               r1_v;
    tpi_pkg::t_op                       r1_op;
    logic signed [tpi_pkg::POINT_W-1:0] r1_a, r1_b;

    // stage 2: clipped segments
    logic            r2_v;
    tpi_pkg::t_flags r2_flags;
    logic [30:0]     r2_u, r2_dl, r2_dr;
    logic [31:0]     r2_sl, r2_sr;
    logic [32:0]     r2_len2, r2_len;

    // stage 3: products
    logic            r3_v;
    tpi_pkg::t_flags r3_flags;
    logic [62:0]     r3_xl, r3_xr;
    logic [47:0]     r3_ud;
    logic [49:0]     r3_dlen;
    logic [32:0]     r3_len;

    // stage 4: sums
    logic                 r4_v;
    tpi_pkg::t_flags      r4_flags;
    logic [62:0]          r4_x;
    logic [48:0]          r4_evn;
    logic signed [AW-1:0] r4_lin;

    // stage 5: depth partial products
    logic                 r5_v;
    tpi_pkg::t_flags      r5_flags;
    logic [48:0]          r5_p0;
    logic [47:0]          r5_p1;
    logic [48:0]          r5_evn;
    logic signed [AW-1:0] r5_lin;

    // stage 6: numerator
    logic                 r6_v;
    tpi_pkg::t_flags      r6_flags;
    logic [NW-1:0]        r6_num;
    logic signed [AW-1:0] r6_lin;

    assign rdy6    = !r6_v || i_ready;
    assign rdy5    = !r5_v || rdy6;
    assign rdy4    = !r4_v || rdy5;
    assign rdy3    = !r3_v || rdy4;
    assign rdy2    = !r2_v || rdy3;
    assign rdy1    = !r1_v || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (rdy1) begin
            r1_v <= i_valid;
        end
        if (rdy1) begin
            r1_op <= i_op;
            r1_a  <= i_point_a;
            r1_b  <= i_point_b;
        end
    end

    logic signed [33:0] a_s, b_s, lo, hi, h_s, p_s, p2, at;
    logic signed [33:0] s1, e1, s2, e2, s3, e3;
    logic               left, right, mid;
    tpi_pkg::t_flags    n2_flags;
    logic [30:0]        n2_u, n2_dl, n2_dr;
    logic [31:0]        n2_sl, n2_sr;
    logic [32:0]        n2_len2, n2_len;

    always_comb begin
        a_s  = 34'(r1_a);
        b_s  = 34'(r1_b);
        lo   = (a_s < b_s) ? a_s : b_s;
        hi   = (a_s < b_s) ? b_s : a_s;
        h_s  = $signed({3'b000, i_cfg.half});
        p_s  = h_s + $signed({3'b000, i_cfg.ramp});
        p2   = p_s <<< 1;
        at   = (a_s < 0) ? -a_s : a_s;

        // left ramp over [-p, -h], flat over [-h, h], right ramp over [h, p]
        s1   = (lo > -p_s) ? lo : -p_s;
        e1   = (hi < -h_s) ? hi : -h_s;
        s2   = (lo > -h_s) ? lo : -h_s;
        e2   = (hi < h_s) ? hi : h_s;
        s3   = (lo > h_s) ? lo : h_s;
        e3   = (hi < p_s) ? hi : p_s;
        left  = s1 < e1;
        mid   = s2 < e2;
        right = s3 < e3;

        n2_dl   = left  ? 31'(e1 - s1) : '0;
        n2_sl   = left  ? 32'(p2 + s1 + e1) : '0;
        n2_dr   = right ? 31'(e3 - s3) : '0;
        n2_sr   = right ? 32'(p2 - s3 - e3) : '0;
        n2_len2 = mid   ? 33'(e2 - s2) : '0;
        n2_len  = 33'(hi - lo);
        n2_u    = 31'(p_s - at);

        n2_flags.op    = r1_op;
        n2_flags.zero  = (r1_a == r1_b);
        n2_flags.neg   = (a_s > b_s);
        n2_flags.flat  = (at < h_s);
        n2_flags.ramp  = (at < p_s);
        n2_flags.rzero = (i_cfg.ramp == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
            if (rdy4) r4_v <= r3_v;
            if (rdy5) r5_v <= r4_v;
            if (rdy6) r6_v <= r5_v;
        end
        if (rdy2) begin
            r2_flags <= n2_flags;
            r2_u     <= n2_u;
            r2_dl    <= n2_dl;
            r2_sl    <= n2_sl;
            r2_dr    <= n2_dr;
            r2_sr    <= n2_sr;
            r2_len2  <= n2_len2;
            r2_len   <= n2_len;
        end
        if (rdy3) begin
            r3_flags <= r2_flags;
            r3_xl    <= 63'(r2_dl) * 63'(r2_sl);
            r3_xr    <= 63'(r2_dr) * 63'(r2_sr);
            r3_ud    <= 48'(r2_u) * 48'(i_cfg.depth);
            r3_dlen  <= 50'(r2_len2) * 50'(i_cfg.depth);
            r3_len   <= r2_len;
        end
        if (rdy4) begin
            r4_flags <= r3_flags;
            r4_x     <= r3_xl + r3_xr;
            r4_evn   <= {r3_ud, 1'b0};
            r4_lin   <= $signed((AW'(r3_len) << FRAC_BITS) - AW'(r3_dlen));
        end
        if (rdy5) begin
            r5_flags <= r4_flags;
            r5_p0    <= 49'(r4_x[31:0]) * 49'(i_cfg.depth);
            r5_p1    <= 48'(r4_x[62:32]) * 48'(i_cfg.depth);
            r5_evn   <= r4_evn;
            r5_lin   <= r4_lin;
        end
        if (rdy6) begin
            r6_flags <= r5_flags;
            r6_lin   <= r5_lin;
            if (r5_flags.op == tpi_pkg::OP_INTEG) begin
                r6_num <= NW'(r5_p0) + (NW'(r5_p1) << 32);
            end else begin
                r6_num <= NW'(r5_evn);
            end
        end
    end

    assign o_valid = r6_v;
    assign o_num   = r6_num;
    assign o_lin   = r6_lin;
    assign o_flags = r6_flags;

endmodule

FILE: hw/rtl/tpi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_div
// Pipelined restoring divider, one quotient bit per stage, with a side
// word that travels along with each request.
// ----------------------------------------------------------------------------
module tpi_div #(
    parameter int DEN_W  = tpi_pkg::DEN_W,
    parameter int QUO_W  = tpi_pkg::QUO_W,
    parameter int SIDE_W = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [DEN_W+QUO_W-1:0] i_num,
    input  logic [DEN_W-1:0]       i_den,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [QUO_W-1:0]       o_quot,
    output logic                   o_rem_nz,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int LAST = QUO_W - 1;

    logic              r_v    [QUO_W];
    logic [DEN_W-1:0]  r_rem  [QUO_W];
    logic [QUO_W-1:0]  r_low  [QUO_W];
    logic [SIDE_W-1:0] r_side [QUO_W];
    logic              rdy    [QUO_W+1];

    assign rdy[QUO_W] = i_ready;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic              pv;
        logic [DEN_W-1:0]  prem;
        logic [QUO_W-1:0]  plow;
        logic [SIDE_W-1:0] pside;
        logic [DEN_W:0]    t;
        logic              ge;

        if (k == 0) begin : g_first
            assign pv    = i_valid;
            assign prem  = i_num[DEN_W+QUO_W-1:QUO_W];
            assign plow  = i_num[QUO_W-1:0];
            assign pside = i_side;
        end else begin : g_next
            assign pv    = r_v[k-1];
            assign prem  = r_rem[k-1];
            assign plow  = r_low[k-1];
            assign pside = r_side[k-1];
        end

        // shift in the next dividend bit, subtract when it fits
        assign t      = {prem, plow[QUO_W-1]};
        assign ge     = (t >= {1'b0, i_den});
        assign rdy[k] = !r_v[k] || rdy[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_v[k] <= pv;
            end
            if (rdy[k]) begin
                r_rem[k]  <= ge ? DEN_W'(t - {1'b0, i_den}) : t[DEN_W-1:0];
                r_low[k]  <= {plow[QUO_W-2:0], ge};
                r_side[k] <= pside;
            end
        end
    end

    assign o_ready  = rdy[0];
    assign o_valid  = r_v[LAST];
    assign o_quot   = r_low[LAST];
    assign o_rem_nz = (r_rem[LAST] != '0);
    assign o_side   = r_side[LAST];

    a_last_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAST] && !i_ready |=> r_v[LAST] && $stable(r_low[LAST]) && $stable(r_rem[LAST]))
        else $error("divider output lost while stalled");

endmodule

FILE: hw/rtl/tpi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_back
// Ramp correction, profile value selection, rounding, sign and saturation,
// then the output register.
// ----------------------------------------------------------------------------
module tpi_back #(
    parameter int FRAC_BITS = tpi_pkg::FRAC_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [tpi_pkg::QUO_W-1:0]                i_quot,
    input  logic                                     i_rem_nz,
    input  logic signed [tpi_pkg::area_width(FRAC_BITS)-1:0] i_lin,
    input  tpi_pkg::t_flags                          i_flags,
    input  logic [tpi_pkg::DEPTH_W-1:0]              i_depth,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic signed [tpi_pkg::VALUE_W-1:0]       o_value
);

    localparam int AW = tpi_pkg::area_width(FRAC_BITS);
    localparam int EW = tpi_pkg::eval_width(FRAC_BITS);
    localparam logic signed [EW-1:0] ONE_EV  = EW'(1) << FRAC_BITS;
    localparam logic signed [AW-1:0] HALF_AR = AW'(1) << (FRAC_BITS - 1);
    localparam logic signed [AW-1:0] SAT_HI  = AW'(tpi_pkg::OUT_MAX);
    localparam logic signed [AW-1:0] SAT_LO  = AW'(tpi_pkg::OUT_MIN);

    logic                 rdy1, rdy_out;
    logic                 r1_v;
    tpi_pkg::t_flags      r1_flags;
    logic signed [AW-1:0] r1_area;
    logic signed [EW-1:0] r1_ev;
    logic                 r_out_v;
    logic signed [tpi_pkg::VALUE_W-1:0] r_value;

    assign rdy_out = !r_out_v || i_ready;
    assign rdy1    = !r1_v || rdy_out;
    assign o_ready = rdy1;

    logic [tpi_pkg::QUO_W:0] dip;
    logic signed [AW-1:0]    n1_area;
    logic signed [EW-1:0]    n1_ev;

    always_comb begin
        // ceiling of the ramp dip area
        dip = i_flags.rzero ? '0 : ((tpi_pkg::QUO_W+1)'(i_quot) + (tpi_pkg::QUO_W+1)'(i_rem_nz));
        n1_area = i_lin - $signed(AW'(dip));
        if (i_flags.flat) begin
            n1_ev = ONE_EV - $signed(EW'(i_depth));
        end else if (i_flags.ramp) begin
            n1_ev = ONE_EV - $signed(EW'(i_quot));
        end else begin
            n1_ev = ONE_EV;
        end
    end

    logic signed [AW-1:0] rd, n_int, n_val, n_sat;

    always_comb begin
        rd = (r1_area + HALF_AR) >>> FRAC_BITS;
        if (r1_flags.zero) begin
            n_int = '0;
        end else if (r1_flags.neg) begin
            n_int = -rd;
        end else begin
            n_int = rd;
        end
        n_val = (r1_flags.op == tpi_pkg::OP_EVAL) ? AW'(r1_ev) : n_int;
        if (n_val > SAT_HI) begin
            n_sat = SAT_HI;
        end else if (n_val < SAT_LO) begin
            n_sat = SAT_LO;
        end else begin
            n_sat = n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (rdy1)    r1_v    <= i_valid;
            if (rdy_out) r_out_v <= r1_v;
        end
        if (rdy1) begin
            r1_flags <= i_flags;
            r1_area  <= n1_area;
            r1_ev    <= n1_ev;
        end
        if (rdy_out) begin
            r_value <= tpi_pkg::VALUE_W'(n_sat);
        end
    end

    assign o_valid = r_out_v;
    assign o_value = r_value;

    a_zero_span : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_v && rdy_out && r1_flags.op == tpi_pkg::OP_INTEG && r1_flags.zero
        |=> o_value == '0)
        else $error("equal bounds gave a nonzero area");

endmodule

FILE: hw/rtl/trapezoid_profile_integrator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_profile_integrator_unit
// Trapezoid dip profile evaluation and exact integration, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tdata holds point_a (bits 31:0) and point_b (bits 63:32),
//   tuser holds op (0 evaluate at point_a, 1 integrate point_a to point_b).
//   Master stream: tdata holds the 35-bit signed value in bits 34:0, upper
//   bits zero. One result per request, in request order.
//   Configuration: write enable, register index (0 depth, 1 half flat width,
//   2 ramp width) and data; write only while no request is in flight.
//   Throughput: one request per cycle while the receiver accepts. Pipeline: 56 register
//   stages, six for segment clipping and products, 48 for the one-bit-per-stage
//   divider by twice the ramp width, two for rounding and saturation.
//   Reset empties the pipeline and loads the register defaults.
//   When the receiver stalls, each stage holds its request and bubbles close
//   up; tready drops only once every stage is occupied.
// ----------------------------------------------------------------------------
module trapezoid_profile_integrator_unit #(
    parameter int FRAC_BITS = tpi_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [63:0]                      i_s_tdata,  // point_a, point_b
    input  logic [0:0]                       i_s_tuser,  // op
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [39:0]                      o_m_tdata,  // value, zero pad
    input  logic                             i_cfg_we,
    input  logic [tpi_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tpi_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW     = tpi_pkg::area_width(FRAC_BITS);
    localparam int SIDE_W = AW + $bits(tpi_pkg::t_flags);

    tpi_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth <= tpi_pkg::DEPTH_RST;
            r_cfg.half  <= tpi_pkg::HALF_RST;
            r_cfg.ramp  <= tpi_pkg::RAMP_RST;
        end else if (i_cfg_we) begin
            case (tpi_pkg::t_cfg_idx'(i_cfg_idx))
                tpi_pkg::REG_DEPTH: r_cfg.depth <= i_cfg_data[tpi_pkg::DEPTH_W-1:0];
                tpi_pkg::REG_HALF:  r_cfg.half  <= i_cfg_data[tpi_pkg::HALF_W-1:0];
                tpi_pkg::REG_RAMP:  r_cfg.ramp  <= i_cfg_data[tpi_pkg::RAMP_W-1:0];
                default: ;
            endcase
        end
    end

    logic                       f_valid, f_ready;
    logic [tpi_pkg::NUM_W-1:0]  f_num;
    logic signed [AW-1:0]       f_lin;
    tpi_pkg::t_flags            f_flags;

    tpi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_op      (tpi_pkg::t_op'(i_s_tuser[0])),
        .i_point_a ($signed(i_s_tdata[31:0])),
        .i_point_b ($signed(i_s_tdata[63:32])),
        .i_cfg     (r_cfg),
        .o_valid   (f_valid),
        .i_ready   (f_ready),
        .o_num     (f_num),
        .o_lin     (f_lin),
        .o_flags   (f_flags)
    );

    logic                       d_valid, d_ready, d_rem_nz;
    logic [tpi_pkg::QUO_W-1:0]  d_quot;
    logic [SIDE_W-1:0]          d_side;
    tpi_pkg::t_flags            d_flags;
    logic signed [AW-1:0]       d_lin;

    tpi_div #(
        .DEN_W  (tpi_pkg::DEN_W),
        .QUO_W  (tpi_pkg::QUO_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (f_valid),
        .o_ready  (f_ready),
        .i_num    (f_num),
        .i_den    ({r_cfg.ramp, 1'b0}),
        .i_side   ({f_lin, f_flags}),
        .o_valid  (d_valid),
        .i_ready  (d_ready),
        .o_quot   (d_quot),
        .o_rem_nz (d_rem_nz),
        .o_side   (d_side)
    );

    assign d_flags = tpi_pkg::t_flags'(d_side[$bits(tpi_pkg::t_flags)-1:0]);
    assign d_lin   = $signed(d_side[SIDE_W-1:$bits(tpi_pkg::t_flags)]);

    logic signed [tpi_pkg::VALUE_W-1:0] b_value;

    tpi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (d_valid),
        .o_ready  (d_ready),
        .i_quot   (d_quot),
        .i_rem_nz (d_rem_nz),
        .i_lin    (d_lin),
        .i_flags  (d_flags),
        .i_depth  (r_cfg.depth),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_value  (b_value)
    );

    assign o_m_tdata = {5'b00000, b_value};

    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("request refused with an empty output register");

endmodule
